// ===== rtl/core/stop_bit_signed_int_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// stop-bit decoder assertion macros
// concurrent checks sampled on the rising clock edge, muted while in reset
// ----------------------------------------------------------------------------
`ifndef STOP_BIT_SIGNED_INT_DECODER_CORE_ASSERT_SVH
`define STOP_BIT_SIGNED_INT_DECODER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stop-bit decoder check failed in the same cycle");

// antecedent implies consequent in the following cycle
`define SBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stop-bit decoder check failed in the following cycle");

`endif

// ===== rtl/core/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbd_pkg
// shared payload types and constants of the stop-bit signed integer decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbd_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DATA_W  = 7;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned COUNT_W = 4;

    // bit positions inside an encoded byte
    localparam int unsigned STOP_BIT = 7;
    localparam int unsigned SIGN_BIT = 6;

    // run length limits
    localparam logic [COUNT_W-1:0] MAX_BYTES = 4'd10;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd15;

    // input transfer payload
    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              buffer_end;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic signed [VALUE_W-1:0] decoded_value;
        logic                      stop_seen;
        logic                      overlong;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/stop_bit_signed_int_decoder_core.sv =====
// Stop-bit signed integer decoder. Takes one encoded byte per cycle on the input
// channel and returns one 64-bit two's complement value for each run of bytes,
// on the byte that carries the stop bit (bit 7) or is marked as the buffer end.
// The first byte's bit 6 gives the sign; every byte shifts its low seven bits
// in, and bits above 63 are dropped. stop_seen tells a stop-bit end from a
// buffer end, and overlong flags runs of more than ten bytes. Each byte is a
// single 64-bit shift-and-merge between the accumulator register and the
// result register, so a byte can be accepted in every cycle, also while a
// finished value waits in the result register as long as it is taken that cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "stop_bit_signed_int_decoder_core_assert.svh"

// ----------------------------------------------------------------------------
// stop_bit_signed_int_decoder_core
// byte-per-cycle decoder of stop-bit encoded signed integers, stalled while a result waits untaken
// ----------------------------------------------------------------------------
module stop_bit_signed_int_decoder_core
    import sbd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // byte input
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    // decoded value output
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    // run state
    logic [VALUE_W-1:0] r_acc,        n_acc;
    logic               r_in_value,   n_in_value;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    // result register
    logic               r_out_valid,  n_out_valid;
    t_out_item          r_out,        n_out;

    logic               in_fire;
    logic               run_end;
    logic [VALUE_W-1:0] acc_base;
    logic [VALUE_W-1:0] acc_shift;
    logic [COUNT_W-1:0] count_base;
    logic [COUNT_W-1:0] count_inc;

    // result register frees up when it is empty or being taken
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sign extension seed on the first byte, then shift in seven data bits
    always_comb begin
        if (r_in_value) begin
            acc_base   = r_acc;
            count_base = r_byte_count;
        end else begin
            acc_base   = i_in_data.byte_in[SIGN_BIT] ? {VALUE_W{1'b1}} : '0;
            count_base = '0;
        end
        acc_shift = {acc_base[VALUE_W-DATA_W-1:0], i_in_data.byte_in[DATA_W-1:0]};
        count_inc = (count_base < COUNT_SAT) ? count_base + 1'b1 : count_base;
        run_end   = i_in_data.byte_in[STOP_BIT] || i_in_data.buffer_end;
    end

    // next state of the run and the result register
    always_comb begin
        n_acc        = r_acc;
        n_in_value   = r_in_value;
        n_byte_count = r_byte_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        if (in_fire) begin
            if (run_end) begin
                n_acc                = '0;
                n_in_value           = 1'b0;
                n_byte_count         = '0;
                n_out_valid          = 1'b1;
                n_out.decoded_value  = acc_shift;
                n_out.stop_seen      = i_in_data.byte_in[STOP_BIT];
                n_out.overlong       = count_inc > MAX_BYTES;
            end else begin
                n_acc        = acc_shift;
                n_in_value   = 1'b1;
                n_byte_count = count_inc;
            end
        end
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_in_value   <= 1'b0;
            r_byte_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_acc        <= n_acc;
            r_in_value   <= n_in_value;
            r_byte_count <= n_byte_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // a byte that ends a run leaves the run state cleared
    `SBD_ASSERT_NEXT(a_run_clears, i_clk, i_rst_n, in_fire && run_end,
        !r_in_value && r_byte_count == '0 && r_acc == '0 && r_out_valid)
    // a byte that continues a run keeps the decoder inside the run
    `SBD_ASSERT_NEXT(a_run_holds, i_clk, i_rst_n, in_fire && !run_end,
        r_in_value && r_byte_count != '0)
    // outside a run the accumulator and count sit at zero
    `SBD_ASSERT_SAME(a_idle_clean, i_clk, i_rst_n, !r_in_value,
        r_acc == '0 && r_byte_count == '0)
    // a new result never overwrites one still waiting
    `SBD_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, in_fire && run_end,
        !r_out_valid || i_out_ready)

endmodule

`default_nettype wire
